/* src/crsc_pkg.sv */
`timescale 1ns / 1ps
// Package with shared constants, codes, the CRC byte step and the sequence comparison for the record slot checker.
package crsc_pkg;

    localparam int HEADER_BYTES      = 20;
    localparam int MAX_PAYLOAD_BYTES = 1024;

    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [31:0] HALF_RANGE = 32'h8000_0000;

    localparam int PAYLOAD_SIZE_W = 11;
    localparam logic [PAYLOAD_SIZE_W-1:0] PAYLOAD_SIZE_RESET = 11'd4;

    typedef enum logic [1:0] {
        CFG_RECORD_MAGIC    = 2'd0,
        CFG_STORAGE_VERSION = 2'd1,
        CFG_CONFIG_VERSION  = 2'd2,
        CFG_PAYLOAD_SIZE    = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        SEL_NONE      = 2'd0,
        SEL_SLOT_A    = 2'd1,
        SEL_SLOT_B    = 2'd2,
        SEL_UNDECIDED = 2'd3
    } t_sel;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    function automatic logic seq_newer(input logic [31:0] cand, input logic [31:0] ref_seq);
        logic [31:0] d;
        d = cand - ref_seq;
        return (d != 32'd0) && (d < HALF_RANGE);
    endfunction

endpackage

/* src/config_record_slot_checker_core.sv */
`timescale 1ns / 1ps
// Top level of the record slot checker: header, CRC and payload checks and slot selection.
//
// The block takes the bytes of stored record images on the slave stream, one byte per
// item: tdata is the byte, tlast marks the final byte of an image, tuser carries the
// slot (bit 0) and the external payload verdict (bit 1, read with tlast).
// Each image's final byte yields one result on the master stream: tdata holds the
// record sequence (bits 31:0) and the selection code (bits 33:32); tuser holds the
// finished slot (bit 0) and the record's validity (bit 1). Other bytes yield no result.
// An accepted byte lands in an input register; the next cycle it runs through the CRC
// byte step and field checks, and a final byte's verdict loads the result register,
// from which the result is offered on the master stream.
// One byte is accepted every cycle while tready is high; the unrolled CRC step sets that rate.
// When the receiver stalls, bytes keep flowing until a final byte reaches the input
// register while the result register is still full; then tready drops until the
// result is taken.
// Reset clears the pipeline, the per-image state, the remembered slot A verdict and
// the registers (payload size returns to 4). Registers are written through the plain
// write port; the user must write them only while the block is idle (not enforced here).
module config_record_slot_checker_core #(
    parameter int HEADER_BYTES      = crsc_pkg::HEADER_BYTES,
    parameter int MAX_PAYLOAD_BYTES = crsc_pkg::MAX_PAYLOAD_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // data_byte
    input  logic        i_s_axis_tlast,   // last_byte
    input  logic [1:0]  i_s_axis_tuser,   // slot, payload_ok
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // record_sequence, selection, zero fill
    output logic [1:0]  o_m_axis_tuser,   // slot_done, record_valid
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int IDX_W = $clog2(HEADER_BYTES + 2048);
    localparam logic [IDX_W-1:0] PAY_START = IDX_W'(HEADER_BYTES);

    // Registers.
    logic [31:0] r_record_magic;
    logic [15:0] r_storage_version;
    logic [15:0] r_config_version;
    logic [crsc_pkg::PAYLOAD_SIZE_W-1:0] r_payload_size;

    // Input stage.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_in_slot;
    logic       r_in_ok;

    // Per-image state.
    logic [IDX_W-1:0] r_byte_index, n_byte_index;
    logic [31:0]      r_crc, n_crc;
    logic [31:0]      r_field, n_field;
    logic [31:0]      r_stored_crc, n_stored_crc;
    logic [31:0]      r_cur_seq, n_cur_seq;
    logic             r_checks_ok, n_checks_ok;
    logic             r_slot_a_valid, n_slot_a_valid;
    logic [31:0]      r_slot_a_seq, n_slot_a_seq;

    // Result stage.
    logic          r_out_valid;
    logic [31:0]   r_out_seq, n_out_seq;
    crsc_pkg::t_sel r_out_sel, n_out_sel;
    logic          r_out_slot;
    logic          r_out_rec_valid, n_out_rec_valid;

    logic             stall;
    logic             advance;
    logic             finish;
    logic [IDX_W-1:0] size;
    logic             size_ok;

    assign stall   = r_in_valid && r_in_last && r_out_valid && !i_m_axis_tready;
    assign advance = !stall;
    assign finish  = advance && r_in_valid && r_in_last;
    assign o_s_axis_tready = advance;

    assign size    = PAY_START + IDX_W'(r_payload_size);
    assign size_ok = (r_payload_size >= crsc_pkg::PAYLOAD_SIZE_W'(4))
                  && (32'(r_payload_size) <= 32'(MAX_PAYLOAD_BYTES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_magic    <= '0;
            r_storage_version <= '0;
            r_config_version  <= '0;
            r_payload_size    <= crsc_pkg::PAYLOAD_SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (crsc_pkg::t_cfg_index'(i_cfg_index))
                crsc_pkg::CFG_RECORD_MAGIC:    r_record_magic    <= i_cfg_data;
                crsc_pkg::CFG_STORAGE_VERSION: r_storage_version <= i_cfg_data[15:0];
                crsc_pkg::CFG_CONFIG_VERSION:  r_config_version  <= i_cfg_data[15:0];
                crsc_pkg::CFG_PAYLOAD_SIZE:
                    r_payload_size <= i_cfg_data[crsc_pkg::PAYLOAD_SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
            r_in_slot <= i_s_axis_tuser[0];
            r_in_ok   <= i_s_axis_tuser[1];
        end
    end

    always_comb begin
        logic [IDX_W-1:0] i;
        logic             take;
        logic             valid;
        i               = r_byte_index;
        take            = r_in_valid && (i < size);
        n_byte_index    = r_byte_index;
        n_crc           = r_crc;
        n_field         = r_field;
        n_stored_crc    = r_stored_crc;
        n_cur_seq       = r_cur_seq;
        n_checks_ok     = r_checks_ok;
        n_slot_a_valid  = r_slot_a_valid;
        n_slot_a_seq    = r_slot_a_seq;
        n_out_seq       = r_out_seq;
        n_out_sel       = r_out_sel;
        n_out_rec_valid = r_out_rec_valid;

        if (take) begin
            n_field = {r_in_byte, r_field[31:8]};
            if ((i < IDX_W'(16)) || (i >= PAY_START)) begin
                n_crc = crsc_pkg::crc_byte(r_crc, r_in_byte);
            end
            if (i == IDX_W'(3) && n_field != r_record_magic) n_checks_ok = 1'b0;
            if (i == IDX_W'(5) && n_field[31:16] != r_storage_version) n_checks_ok = 1'b0;
            if (i == IDX_W'(7) && n_field[31:16] != r_config_version) n_checks_ok = 1'b0;
            if (i == IDX_W'(11)) n_cur_seq = n_field;
            if (i == IDX_W'(15) && n_field != 32'(r_payload_size)) n_checks_ok = 1'b0;
            if (i == IDX_W'(19)) n_stored_crc = n_field;
            if (i == IDX_W'(HEADER_BYTES + 1) && n_field[31:16] != r_config_version) begin
                n_checks_ok = 1'b0;
            end
            if ((i == IDX_W'(HEADER_BYTES + 2) || i == IDX_W'(HEADER_BYTES + 3))
                    && r_in_byte != 8'd0) begin
                n_checks_ok = 1'b0;
            end
            n_byte_index = i + IDX_W'(1);
        end

        valid = n_checks_ok && r_in_ok && size_ok && (n_byte_index == size)
             && (~n_crc == n_stored_crc);

        if (finish) begin
            n_out_rec_valid = valid;
            if (!r_in_slot) begin
                n_slot_a_valid = valid;
                n_slot_a_seq   = valid ? n_cur_seq : 32'd0;
                n_out_seq      = valid ? n_cur_seq : 32'd0;
                n_out_sel      = crsc_pkg::SEL_UNDECIDED;
            end else begin
                priority if (!r_slot_a_valid && !valid) begin
                    n_out_seq = 32'd0;
                    n_out_sel = crsc_pkg::SEL_NONE;
                end else if (!valid || (r_slot_a_valid
                        && !crsc_pkg::seq_newer(n_cur_seq, r_slot_a_seq))) begin
                    n_out_seq = r_slot_a_seq;
                    n_out_sel = crsc_pkg::SEL_SLOT_A;
                end else begin
                    n_out_seq = n_cur_seq;
                    n_out_sel = crsc_pkg::SEL_SLOT_B;
                end
                n_slot_a_valid = 1'b0;
                n_slot_a_seq   = 32'd0;
            end
            n_byte_index = '0;
            n_crc        = crsc_pkg::CRC_INIT;
            n_field      = 32'd0;
            n_stored_crc = 32'd0;
            n_cur_seq    = 32'd0;
            n_checks_ok  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index   <= '0;
            r_crc          <= crsc_pkg::CRC_INIT;
            r_field        <= '0;
            r_stored_crc   <= '0;
            r_cur_seq      <= '0;
            r_checks_ok    <= 1'b1;
            r_slot_a_valid <= 1'b0;
            r_slot_a_seq   <= '0;
        end else if (advance) begin
            r_byte_index   <= n_byte_index;
            r_crc          <= n_crc;
            r_field        <= n_field;
            r_stored_crc   <= n_stored_crc;
            r_cur_seq      <= n_cur_seq;
            r_checks_ok    <= n_checks_ok;
            r_slot_a_valid <= n_slot_a_valid;
            r_slot_a_seq   <= n_slot_a_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_seq       <= n_out_seq;
            r_out_sel       <= n_out_sel;
            r_out_slot      <= r_in_slot;
            r_out_rec_valid <= n_out_rec_valid;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_sel, r_out_seq};
    assign o_m_axis_tuser  = {r_out_rec_valid, r_out_slot};

`ifndef SYNTHESIS
    // A slot A result never decides the selection.
    a_slot_a_undecided: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_slot) |-> (r_out_sel == crsc_pkg::SEL_UNDECIDED))
        else $error("slot A result with a decided selection");

    // An invalid slot A record reports a zero sequence.
    a_slot_a_seq_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_slot && !r_out_rec_valid) |-> (r_out_seq == 32'd0))
        else $error("invalid slot A record with a nonzero sequence");

    // Slot B is selected only when it is valid itself.
    a_slot_b_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sel == crsc_pkg::SEL_SLOT_B) |-> r_out_rec_valid)
        else $error("slot B selected without a valid record");

    // The remembered slot A sequence is zero whenever slot A is not valid.
    a_slot_a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_slot_a_valid |-> (r_slot_a_seq == 32'd0))
        else $error("stale slot A sequence");

    // The image state starts over after a final byte.
    a_image_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (r_byte_index == '0 && r_checks_ok))
        else $error("image state not cleared after final byte");
`endif

endmodule
